// ----- design/sts_pkg.sv -----
// Shared types and constants for the sorted table search block.
`timescale 1ns / 1ps

package sts_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned INDEX_W   = 10;
  localparam int unsigned ADDR_W    = 16;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_EXACT = 2'd1;
  localparam logic [1:0] OP_LOWER = 2'd2;
  localparam logic [1:0] OP_UPPER = 2'd3;

  // One access to the element store per cycle.
  typedef struct packed {
    logic               wr_en;
    logic               rd_en;
    logic [ADDR_W-1:0]  addr;
    logic [VALUE_W-1:0] wdata;
  } ram_req_t;

  // Search result handed from the engine to the output register.
  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] position;
  } search_res_t;

endpackage

// ----- design/sts_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps

module sts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/sts_engine.sv -----
// Request decode and binary search sequencer driving the element store.
`timescale 1ns / 1ps

module sts_engine
  import sts_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                opcode_i,
  input  logic [INDEX_W-1:0]        entry_index_i,
  input  logic signed [VALUE_W-1:0] operand_value_i,
  input  logic [COUNT_W-1:0]        count_i,
  output ram_req_t                  ram_req_o,
  input  logic [VALUE_W-1:0]        ram_rdata_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output search_res_t               res_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_PROBE  = 2'd1;
  localparam logic [1:0] ST_CMP    = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  localparam logic [ADDR_W:0] DEPTH_EXT = (ADDR_W + 1)'(TABLE_DEPTH);

  logic [1:0]                state_q, state_d;
  logic [1:0]                op_q, op_d;
  logic signed [VALUE_W-1:0] target_q, target_d;
  logic [COUNT_W-1:0]        lo_q, lo_d;
  logic signed [COUNT_W:0]   hi_q, hi_d;
  logic [COUNT_W-1:0]        mid_q, mid_d;
  search_res_t               res_q, res_d;

  logic                      accept;
  logic signed [VALUE_W-1:0] elem;
  logic                      go_low;
  logic                      hit;
  logic [COUNT_W-1:0]        lo_n;
  logic signed [COUNT_W:0]   hi_n;
  logic [COUNT_W:0]          sum_n;
  logic [COUNT_W:0]          cnt_m1;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign res_valid_o = (state_q == ST_FINISH);
  assign res_o       = res_q;
  assign elem        = $signed(ram_rdata_i);
  assign cnt_m1      = {1'b0, count_i} - 1'b1;

  // Probe decision: hit for exact, otherwise which half to keep.
  always_comb begin
    hit    = 1'b0;
    go_low = 1'b0;
    case (op_q)
      OP_EXACT: begin
        hit    = (elem == target_q);
        go_low = (elem > target_q);
      end
      OP_LOWER: go_low = (elem >= target_q);
      OP_UPPER: go_low = !(elem <= target_q);
      default:  go_low = 1'b0;
    endcase
    if (go_low) begin
      lo_n = lo_q;
      hi_n = $signed({1'b0, mid_q}) - 12'sd1;
    end else begin
      lo_n = mid_q + 1'b1;
      hi_n = hi_q;
    end
    sum_n = {1'b0, lo_n} + $unsigned(hi_n);
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    target_d  = target_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    res_d     = res_q;
    ram_req_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_WRITE) begin
            ram_req_o.wr_en = ({7'b0, entry_index_i} < DEPTH_EXT);
            ram_req_o.addr  = {6'b0, entry_index_i};
            ram_req_o.wdata = operand_value_i;
          end else begin
            op_d     = opcode_i;
            target_d = operand_value_i;
            lo_d     = '0;
            hi_d     = $signed(cnt_m1);
            mid_d    = cnt_m1[COUNT_W:1];
            if (count_i == '0) begin
              res_d   = '0;
              state_d = ST_FINISH;
            end else begin
              state_d = ST_PROBE;
            end
          end
        end
      end
      ST_PROBE: begin
        ram_req_o.rd_en = 1'b1;
        ram_req_o.addr  = {5'b0, mid_q};
        state_d         = ST_CMP;
      end
      ST_CMP: begin
        lo_d  = lo_n;
        hi_d  = hi_n;
        mid_d = sum_n[COUNT_W:1];
        if (hit) begin
          res_d.found    = 1'b1;
          res_d.position = mid_q[INDEX_W-1:0];
          state_d        = ST_FINISH;
        end else if ($signed({1'b0, lo_n}) <= hi_n) begin
          state_d = ST_PROBE;
        end else begin
          // Bounds report lo unless it ran off the end of the searched range.
          if ((op_q != OP_EXACT) && (lo_n < count_i)) begin
            res_d.found    = 1'b1;
            res_d.position = lo_n[INDEX_W-1:0];
          end else begin
            res_d = '0;
          end
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    target_q <= target_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    res_q    <= res_d;
  end

  a_cmp_after_probe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> ($past(state_q) == ST_PROBE))
    else $error("compare without a preceding memory read");

  a_probe_in_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE) |-> ($signed({1'b0, lo_q}) <= hi_q))
    else $error("probe issued with an empty search window");

  a_query_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (opcode_i != OP_WRITE)) |=> (state_q != ST_IDLE))
    else $error("query request dropped");

  a_notfound_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_q.found) |-> (res_q.position == '0))
    else $error("not-found result with non-zero position");

endmodule

// ----- design/sorted_table_binary_search.sv -----
// Top level of the sorted table search block: count register, store and output stage.
`timescale 1ns / 1ps
//
// Holds an ascending table of signed 32-bit elements in a single-port RAM.
// Input channel (in_valid_i / in_ready_o) carries one request: opcode_i
// selects write element, exact search, lower bound or upper bound;
// entry_index_i is the write address, operand_value_i the element or target.
// Writes give no result; a write at an index not below TABLE_DEPTH is
// dropped. Queries give one result on the output channel (out_valid_o /
// out_ready_i): found_o and position_o, position zero when nothing is found.
// cfg_we_i / cfg_wdata_i load entries_in_use, saturated to TABLE_DEPTH;
// write it only while no query is in flight.
// A query walks floor midpoints, one probe being a RAM read then a compare,
// and takes P <= floor(log2(count)) + 1 probes (at most 11 for 1024 entries).
// A new request is taken once the result has moved to the output register,
// so a result waiting there does not block the next request; if the receiver
// stalls with a result still held, the finished query waits in the engine.
// Reset clears the count and all handshake state; table contents are not
// cleared and must be written before they are searched.
//

module sorted_table_binary_search
  import sts_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                opcode_i,
  input  logic [INDEX_W-1:0]        entry_index_i,
  input  logic signed [VALUE_W-1:0] operand_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      found_o,
  output logic [INDEX_W-1:0]        position_o,
  input  logic                      cfg_we_i,
  input  logic [COUNT_W-1:0]        cfg_wdata_i
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [ADDR_W:0] DEPTH_EXT = (ADDR_W + 1)'(TABLE_DEPTH);

  logic [COUNT_W-1:0] cfg_q;
  logic [COUNT_W-1:0] count;
  ram_req_t           ram_req;
  logic [VALUE_W-1:0] ram_rdata;
  logic               res_valid;
  logic               res_ready;
  search_res_t        res;
  logic               out_valid_q, out_valid_d;
  search_res_t        out_q;

  // entries_in_use, clipped to the table size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  assign count = ({6'b0, cfg_q} > DEPTH_EXT) ? COUNT_W'(TABLE_DEPTH) : cfg_q;

  sts_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .wr_en_i (ram_req.wr_en),
    .rd_en_i (ram_req.rd_en),
    .addr_i  (ram_req.addr[AW-1:0]),
    .wdata_i (ram_req.wdata),
    .rdata_o (ram_rdata)
  );

  sts_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .entry_index_i   (entry_index_i),
    .operand_value_i (operand_value_i),
    .count_i         (count),
    .ram_req_o       (ram_req),
    .ram_rdata_i     (ram_rdata),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res)
  );

  // Output register: free when empty or being drained this cycle.
  assign res_ready   = !out_valid_q || out_ready_i;
  assign out_valid_d = (res_valid && res_ready) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = out_q.found;
  assign position_o  = out_q.position;

endmodule

// ----- bench/tb_sorted_table_binary_search.sv -----
// Self-checking bench for the sorted table search block: random requests against a search model.
`timescale 1ns / 1ps

module tb_sorted_table_binary_search;
  import sts_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

  // One request as it goes on the wire.
  typedef struct packed {
    logic [1:0]         op;
    logic [INDEX_W-1:0] idx;
    logic [VALUE_W-1:0] value;
  } table_req_t;

  logic                      clk_i           = 1'b0;
  logic                      rst_ni          = 1'b0;
  logic                      in_valid_i      = 1'b0;
  logic                      in_ready_o;
  logic [1:0]                opcode_i        = OP_WRITE;
  logic [INDEX_W-1:0]        entry_index_i   = '0;
  logic signed [VALUE_W-1:0] operand_value_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i     = 1'b0;
  logic                      found_o;
  logic [INDEX_W-1:0]        position_o;
  logic                      cfg_we_i        = 1'b0;
  logic [COUNT_W-1:0]        cfg_wdata_i     = '0;

  // Requests waiting for the driver, and search answers waiting for the output channel.
  table_req_t  requests_to_send[$];
  search_res_t awaited_positions[$];

  // Table contents as the block holds them (updated on acceptance) and as they
  // will be once every queued request has gone (updated on queueing, used to aim targets).
  logic signed [VALUE_W-1:0] shadow_table  [TABLE_DEPTH];
  logic signed [VALUE_W-1:0] planned_table [TABLE_DEPTH];
  logic [COUNT_W-1:0]        count_cfg   = '0;  // mirrors entries_in_use, reset value 0
  int                        filled_len  = 0;   // leading entries known to be written

  bit idle_on    = 1'b0;
  int send_gap   = 0;
  int recv_stall = 0;
  int mismatch_count = 0;

  sorted_table_binary_search #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .entry_index_i  (entry_index_i),
    .operand_value_i(operand_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .found_o        (found_o),
    .position_o     (position_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic log_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Searched length: the count register saturates at the table depth.
  function automatic int effective_count();
    return (count_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_cfg);
  endfunction

  // Search model. Probes floor midpoints over the searched range; exact search
  // stops on the first probe that matches, the bounds run to the end and report
  // the settling point unless it fell off the end of the range.
  function automatic search_res_t find_position(logic [1:0] op,
                                                logic signed [VALUE_W-1:0] target);
    int lo, hi, mid, cnt;
    logic signed [VALUE_W-1:0] elem;
    search_res_t res;
    res = '0;
    cnt = effective_count();
    lo  = 0;
    hi  = cnt - 1;
    while (lo <= hi) begin
      mid  = lo + (hi - lo) / 2;
      elem = shadow_table[mid];
      case (op)
        OP_EXACT: begin
          if (elem == target) begin
            res.found    = 1'b1;
            res.position = INDEX_W'(mid);
            return res;
          end
          if (elem > target) hi = mid - 1;
          else lo = mid + 1;
        end
        OP_LOWER: begin
          if (elem >= target) hi = mid - 1;
          else lo = mid + 1;
        end
        default: begin
          if (elem <= target) lo = mid + 1;
          else hi = mid - 1;
        end
      endcase
    end
    if (op != OP_EXACT && lo < cnt) begin
      res.found    = 1'b1;
      res.position = INDEX_W'(lo);
    end
    return res;
  endfunction

  // Request driver. On acceptance the request is applied to the shadow table
  // or turned into an expected answer; then the next request goes out, with
  // the odd random gap after it while idling is on.
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    table_req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        if (opcode_i == OP_WRITE) shadow_table[entry_index_i] = operand_value_i;
        else awaited_positions.push_back(find_position(opcode_i, operand_value_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (requests_to_send.size() > 0) begin
          nxt = requests_to_send.pop_front();
          in_valid_i      <= 1'b1;
          opcode_i        <= nxt.op;
          entry_index_i   <= nxt.idx;
          operand_value_i <= nxt.value;
          if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 10);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each answer with the oldest expectation and
  // applies receiver back-pressure in random bursts while idling is on.
  always @(posedge clk_i or negedge rst_ni) begin : collect_results
    search_res_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (awaited_positions.size() == 0) begin
          log_mismatch("result with no query outstanding");
        end else begin
          want = awaited_positions.pop_front();
          if (found_o !== want.found)
            log_mismatch($sformatf("found_o %b, expected %b", found_o, want.found));
          if (position_o !== want.position)
            log_mismatch($sformatf("position_o %0d, expected %0d", position_o, want.position));
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        recv_stall = $urandom_range(0, 9);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic void push_req(logic [1:0] op, int unsigned idx,
                                   logic [VALUE_W-1:0] val);
    table_req_t r;
    r.op    = op;
    r.idx   = idx[INDEX_W-1:0];
    r.value = val;
    requests_to_send.push_back(r);
    if (op == OP_WRITE) planned_table[r.idx] = val;
  endfunction

  // Block idle: nothing queued or on the wire, no answer owed. Sampled on the
  // falling edge so the driver's updates have settled; then the worst-case
  // query latency passes before anything else happens.
  task automatic drain();
    while (requests_to_send.size() != 0 || in_valid_i || awaited_positions.size() != 0)
      @(negedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic set_count(int unsigned v);
    drain();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v[COUNT_W-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    count_cfg = v[COUNT_W-1:0];
  endtask

  // Writes entries 0..n-1 in ascending order: tightly packed with many
  // repeats, spread over the whole signed range, or loose from a random start.
  task automatic fill_ascending(int n);
    longint cur, step_max;
    case ($urandom_range(0, 2))
      0: begin
        cur      = longint'($urandom_range(0, 100)) - 50;
        step_max = 2;
      end
      1: begin
        cur      = longint'(VALUE_MIN) + $urandom_range(0, 3);
        step_max = 64'h2_0000_0000 / n;
      end
      default: begin
        cur      = longint'($signed($urandom));
        step_max = 64'd1 << $urandom_range(0, 24);
      end
    endcase
    if (step_max > 64'hFFFF_FFFF) step_max = 64'hFFFF_FFFF;
    for (int i = 0; i < n; i++) begin
      push_req(OP_WRITE, i, cur[VALUE_W-1:0]);
      cur += $urandom_range(0, step_max);
      if (cur > longint'(VALUE_MAX)) cur = longint'(VALUE_MAX);
    end
    if (n > filled_len) filled_len = n;
  endtask

  // Mostly queries aimed at or next to stored elements; now and then a stray
  // write, which may land inside the searched range and spoil the ordering.
  task automatic queue_queries(int k);
    int cnt, off;
    logic [1:0] op;
    logic signed [VALUE_W-1:0] target;
    for (int q = 0; q < k; q++) begin
      cnt = effective_count();
      if ($urandom_range(0, 11) == 0) begin
        if (filled_len > 0 && $urandom_range(0, 1) == 1)
          push_req(OP_WRITE, $urandom_range(0, filled_len - 1), $urandom);
        else
          push_req(OP_WRITE, $urandom_range(0, TABLE_DEPTH - 1), $urandom);
      end else begin
        case ($urandom_range(0, 2))
          0:       op = OP_EXACT;
          1:       op = OP_LOWER;
          default: op = OP_UPPER;
        endcase
        off = int'($urandom_range(0, 2)) - 1;
        case ($urandom_range(0, 9))
          0:       target = VALUE_MIN;
          1:       target = VALUE_MAX;
          2:       target = $urandom;
          default: target = (cnt > 0) ? planned_table[$urandom_range(0, cnt - 1)] + off
                                      : $urandom;
        endcase
        push_req(op, $urandom_range(0, TABLE_DEPTH - 1), target);
      end
    end
  endtask

  // Queries over the whole depth that only ever probe the outermost paths:
  // targets at the bottom walk the left spine, those at the top the right.
  task automatic query_spines();
    push_req(OP_LOWER, 0, VALUE_MIN);
    push_req(OP_UPPER, 0, VALUE_MIN);
    push_req(OP_EXACT, 0, VALUE_MIN);
    push_req(OP_EXACT, 0, VALUE_MIN + 1);
    push_req(OP_LOWER, 0, VALUE_MAX);
    push_req(OP_UPPER, 0, VALUE_MAX);  // bound runs off the end
    push_req(OP_EXACT, 0, VALUE_MAX);
    push_req(OP_UPPER, 0, VALUE_MAX - 1);
  endtask

  initial begin : stimulus
    int n;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    idle_on = 1'b1;

    // Count is zero out of reset: every query must miss
    push_req(OP_EXACT, 0, 0);
    push_req(OP_LOWER, 10'h3FF, VALUE_MIN);
    push_req(OP_UPPER, 0, VALUE_MAX);

    // Six entries: both extremes and a run of repeats in the middle
    push_req(OP_WRITE, 0, VALUE_MIN);
    push_req(OP_WRITE, 1, -5);
    push_req(OP_WRITE, 2, 7);
    push_req(OP_WRITE, 3, 7);
    push_req(OP_WRITE, 4, 7);
    push_req(OP_WRITE, 5, VALUE_MAX);
    filled_len = 6;
    set_count(6);
    push_req(OP_EXACT, 0, VALUE_MIN);
    push_req(OP_EXACT, 0, VALUE_MAX);
    push_req(OP_EXACT, 0, 7);
    push_req(OP_EXACT, 0, 8);          // absent target
    push_req(OP_LOWER, 0, VALUE_MIN);
    push_req(OP_LOWER, 0, VALUE_MAX);
    push_req(OP_LOWER, 0, 8);
    push_req(OP_UPPER, 0, 7);
    push_req(OP_UPPER, 0, VALUE_MAX);  // bound runs off the end
    push_req(OP_UPPER, 0, VALUE_MIN);
    // Out-of-order table: same probe path, no error
    push_req(OP_WRITE, 1, VALUE_MAX);
    push_req(OP_EXACT, 0, -5);
    // Top slot, outside the searched range
    push_req(OP_WRITE, 10'h3FF, 32'h5555_5555);

    // Random phases: refill a prefix, move the count, then query
    for (int ph = 0; ph < 9; ph++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0:       n = 0;
        1, 2:    n = $urandom_range(25, 60);
        default: n = $urandom_range(1, 24);
      endcase
      if (n > 0) fill_ascending(n);
      set_count((n > 0 && $urandom_range(0, 3) != 0) ? n : $urandom_range(0, filled_len));
      queue_queries($urandom_range(15, 30));
    end

    // Whole depth with only the two outer probe paths written: count above
    // the depth saturates, then exactly full, then empty
    idle_on = 1'b1;
    for (int i = 0; i < TABLE_DEPTH / 2; i = 2 * i + 1)
      push_req(OP_WRITE, i, VALUE_MIN + i);
    for (int s = 256; s >= 1; s = s / 2)
      push_req(OP_WRITE, TABLE_DEPTH - 1 - s, VALUE_MAX - s);
    push_req(OP_WRITE, TABLE_DEPTH - 1, VALUE_MAX);
    set_count(11'h7FF);
    query_spines();
    set_count(TABLE_DEPTH);
    query_spines();
    set_count(0);
    queue_queries(4);

    // Closing stretch at full rate
    set_count($urandom_range(1, filled_len));
    idle_on = 1'b0;
    queue_queries(20);
    drain();

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- files.f -----
design/sts_pkg.sv
design/sts_ram.sv
design/sts_engine.sv
design/sorted_table_binary_search.sv
bench/tb_sorted_table_binary_search.sv
